### design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/skrt_pkg.sv
`default_nettype none

package skrt_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 16;

  // Configuration port
  localparam int          CFG_ADDR_W   = 3;
  localparam logic        REG_KEY_LOW  = 1'b0;
  localparam logic        REG_KEY_HIGH = 1'b1;
  localparam logic [15:0] KEY_LOW_RST  = 16'd10601;
  localparam logic [15:0] KEY_HIGH_RST = 16'd10650;

  // Field index inside one record
  localparam int FLD_KEY = 0;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_MODIFY,
    KIND_DELETE,
    KIND_READ
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_WINDOW,
    STAT_DUP,
    STAT_MISSING,
    STAT_FULL,
    STAT_SELECT,
    STAT_POSITION
  } status_t;

  // Score select doubles as the field index inside a record
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_FIRST,
    SEL_SECOND,
    SEL_THIRD
  } score_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_APPLY
  } state_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic       shift_up;
    logic       shift_down;
    logic       put_score;
    score_sel_t score_sel;
  } cell_ctl_t;

endpackage

`default_nettype wire

### design/skrt_cell.sv
`default_nettype none

// One slot of the sorted table: holds a record, compares it against the
// broadcast key and trades records with its neighbors on a shift.
module skrt_cell #(
  parameter int VW  = skrt_pkg::VALUE_WIDTH_DEF,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire logic [CW-1:0]         count_i,
  input  wire logic [5:0]            position_i,
  input  wire logic [3:0][VW-1:0]    new_rec_i,
  input  wire logic [VW-1:0]         new_score_i,
  input  wire skrt_pkg::cell_ctl_t   ctl_i,
  input  wire logic                  prev_lt_i,
  input  wire logic [3:0][VW-1:0]    prev_rec_i,
  input  wire logic [3:0][VW-1:0]    next_rec_i,
  output logic [3:0][VW-1:0]         rec_o,
  output logic                       lt_o,
  output logic                       eq_o,
  output logic                       hit_o
);

  logic [3:0][VW-1:0] rec_r, rec_nxt;
  logic               lt_r, eq_r, hit_r;
  logic               occ;
  logic               at_slot;

  assign occ     = CW'(IDX) < count_i;
  assign at_slot = !lt_r && prev_lt_i;

  // Compare flags against the current command
  always_ff @(posedge clk) begin
    lt_r  <= occ && (rec_r[skrt_pkg::FLD_KEY] < new_rec_i[skrt_pkg::FLD_KEY]);
    eq_r  <= occ && (rec_r[skrt_pkg::FLD_KEY] == new_rec_i[skrt_pkg::FLD_KEY]);
    hit_r <= 32'(position_i) == 32'(IDX);
  end

  // Shift, place or patch the record
  always_comb begin
    rec_nxt = rec_r;
    if (ctl_i.shift_up) begin
      if (at_slot) begin
        rec_nxt = new_rec_i;
      end else if (!lt_r) begin
        rec_nxt = prev_rec_i;
      end
    end
    if (ctl_i.shift_down && !lt_r) begin
      rec_nxt = next_rec_i;
    end
    if (ctl_i.put_score && eq_r) begin
      rec_nxt[ctl_i.score_sel] = new_score_i;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_o = rec_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;
  assign hit_o = hit_r;

endmodule

`default_nettype wire

### design/skrt_scan.sv
`default_nettype none

// Gather the row's flags: key found, insertion or match slot, read record.
module skrt_scan #(
  parameter int N  = skrt_pkg::CAPACITY_DEF,
  parameter int VW = skrt_pkg::VALUE_WIDTH_DEF,
  parameter int IW = 6
) (
  input  wire logic [N-1:0]                 lt_i,
  input  wire logic [N-1:0]                 eq_i,
  input  wire logic [N-1:0]                 hit_i,
  input  wire logic [N-1:0][3:0][VW-1:0]    rec_i,
  output logic                              found_o,
  output logic [IW-1:0]                     slot_o,
  output logic [3:0][VW-1:0]                read_rec_o
);

  logic [N-1:0] bnd;

  // Sorted keys make the less-than flags a prefix; its end is the slot
  assign bnd     = ~lt_i & {lt_i[N-2:0], 1'b1};
  assign found_o = |eq_i;

  // Encode the boundary and select the addressed record
  always_comb begin
    slot_o     = '0;
    read_rec_o = '0;
    for (int i = 0; i < N; i++) begin
      if (bnd[i]) begin
        slot_o = slot_o | IW'(i);
      end
      if (hit_i[i]) begin
        read_rec_o = read_rec_o | rec_i[i];
      end
    end
  end

endmodule

`default_nettype wire

### design/sorted_key_record_table.sv
// Channel  Dir  Handshake         Payload
// in       in   tvalid/tready     tuser: kind; tdata: key, scores, select, new score, position
// out      out  tvalid/tready     tuser: status; tdata: slot, count, read record
// cfg      in   APB psel/penable  key_low at 0x0, key_high at 0x4; pready tied high
//
// After an item is accepted, every cell compares its key against it, then the
// row's flags are scanned and the decision is registered, then the cell row
// shifts and the result register loads.
// The next item can be accepted in the cycle after the result is loaded; no new
// item is taken while one is in progress.
// A result not yet taken holds the apply step; the output register holds it.
// Reset (synchronous, rst_n low) empties the table and restores the key window.
`default_nettype none

`include "assert_macros.svh"

module sorted_key_record_table #(
  parameter int CAPACITY    = skrt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = skrt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input items
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [15:0] key, [31:16] first_score, [47:32] second_score, [63:48] third_score,
  // [65:64] score_select, [81:66] new_score, [87:82] position
  input  wire logic [87:0]                     in_tdata,
  // [1:0] kind
  input  wire logic [1:0]                      in_tuser,
  // result items
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [5:0] slot, [12:6] entry_count, [28:13] read_key, [44:29] read_first,
  // [60:45] read_second, [76:61] read_third, [79:77] zero
  output logic [79:0]                          out_tdata,
  // [2:0] status
  output logic [2:0]                           out_tuser,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [skrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  // Configuration registers
  logic [15:0] key_low_r, key_high_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = 32'((paddr[2] == skrt_pkg::REG_KEY_HIGH) ? key_high_r : key_low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= skrt_pkg::KEY_LOW_RST;
      key_high_r <= skrt_pkg::KEY_HIGH_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == skrt_pkg::REG_KEY_HIGH) begin
        key_high_r <= pwdata[15:0];
      end else begin
        key_low_r <= pwdata[15:0];
      end
    end
  end

  // Control
  skrt_pkg::state_t state_r, state_nxt;
  logic             in_acc;
  logic             out_free;
  logic             apply_go;
  logic             out_tvalid_r;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skrt_pkg::S_IDLE:  if (in_acc) state_nxt = skrt_pkg::S_CMP;
      skrt_pkg::S_CMP:   state_nxt = skrt_pkg::S_DEC;
      skrt_pkg::S_DEC:   state_nxt = skrt_pkg::S_APPLY;
      skrt_pkg::S_APPLY: if (out_free) state_nxt = skrt_pkg::S_IDLE;
      default:           state_nxt = skrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    apply_go  = 1'b0;
    unique case (state_r)
      skrt_pkg::S_IDLE:  in_tready = 1'b1;
      skrt_pkg::S_APPLY: apply_go = out_free;
      default: begin
        in_tready = 1'b0;
        apply_go  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skrt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command register
  skrt_pkg::kind_t      kind_r;
  skrt_pkg::score_sel_t sel_r;
  logic [3:0][VW-1:0]   new_rec_r;
  logic [VW-1:0]        nscore_r;
  logic [5:0]           pos_r;
  logic                 win_r;
  logic [VW-1:0]        in_key;

  assign in_key = VW'(in_tdata[15:0]);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r       <= skrt_pkg::kind_t'(in_tuser);
      new_rec_r[0] <= in_key;
      new_rec_r[1] <= VW'(in_tdata[31:16]);
      new_rec_r[2] <= VW'(in_tdata[47:32]);
      new_rec_r[3] <= VW'(in_tdata[63:48]);
      sel_r        <= skrt_pkg::score_sel_t'(in_tdata[65:64]);
      nscore_r     <= VW'(in_tdata[81:66]);
      pos_r        <= in_tdata[87:82];
      win_r        <= (32'(in_key) >= 32'(key_low_r)) && (32'(in_key) <= 32'(key_high_r));
    end
  end

  // Cell row
  logic [CW-1:0]                       count_r, count_nxt;
  logic [CAPACITY-1:0][3:0][VW-1:0]    cell_rec;
  logic [CAPACITY-1:0]                 cell_lt, cell_eq, cell_hit;
  skrt_pkg::cell_ctl_t                 ctl_r, cell_ctl;

  assign cell_ctl = apply_go ? ctl_r : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_lt;
    logic [3:0][VW-1:0] prev_rec, next_rec;

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_rec = '0;
    end else begin : g_mid
      assign prev_lt  = cell_lt[i-1];
      assign prev_rec = cell_rec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_rec = cell_rec[i];
    end else begin : g_body
      assign next_rec = cell_rec[i+1];
    end

    skrt_cell #(
      .VW  (VW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .count_i     (count_r),
      .position_i  (pos_r),
      .new_rec_i   (new_rec_r),
      .new_score_i (nscore_r),
      .ctl_i       (cell_ctl),
      .prev_lt_i   (prev_lt),
      .prev_rec_i  (prev_rec),
      .next_rec_i  (next_rec),
      .rec_o       (cell_rec[i]),
      .lt_o        (cell_lt[i]),
      .eq_o        (cell_eq[i]),
      .hit_o       (cell_hit[i])
    );
  end

  logic               scan_found;
  logic [IW-1:0]      scan_slot;
  logic [3:0][VW-1:0] scan_rec;

  skrt_scan #(
    .N  (CAPACITY),
    .VW (VW),
    .IW (IW)
  ) u_scan (
    .lt_i       (cell_lt),
    .eq_i       (cell_eq),
    .hit_i      (cell_hit),
    .rec_i      (cell_rec),
    .found_o    (scan_found),
    .slot_o     (scan_slot),
    .read_rec_o (scan_rec)
  );

  // Decide status, slot and cell command
  skrt_pkg::status_t   d_stat, stat_r;
  logic [5:0]          d_slot, slot_r;
  skrt_pkg::cell_ctl_t d_ctl;
  logic [3:0][15:0]    d_rd, rd_r;
  logic                d_ins, d_del, ins_r, del_r;

  always_comb begin
    d_stat = skrt_pkg::STAT_OK;
    d_slot = '0;
    d_ctl  = '0;
    d_rd   = '0;
    d_ins  = 1'b0;
    d_del  = 1'b0;
    if (kind_r == skrt_pkg::KIND_READ) begin
      if (32'(pos_r) < 32'(count_r)) begin
        d_slot = pos_r;
        for (int f = 0; f < 4; f++) begin
          d_rd[f] = 16'(scan_rec[f]);
        end
      end else begin
        d_stat = skrt_pkg::STAT_POSITION;
      end
    end else if (!win_r) begin
      d_stat = skrt_pkg::STAT_WINDOW;
    end else if (kind_r == skrt_pkg::KIND_INSERT) begin
      if (scan_found) begin
        d_stat = skrt_pkg::STAT_DUP;
      end else if (count_r == CW'(CAPACITY)) begin
        d_stat = skrt_pkg::STAT_FULL;
      end else begin
        d_slot         = 6'(scan_slot);
        d_ctl.shift_up = 1'b1;
        d_ins          = 1'b1;
      end
    end else if (!scan_found) begin
      d_stat = skrt_pkg::STAT_MISSING;
    end else if (kind_r == skrt_pkg::KIND_MODIFY) begin
      if (sel_r == skrt_pkg::SEL_NONE) begin
        d_stat = skrt_pkg::STAT_SELECT;
      end else begin
        d_slot          = 6'(scan_slot);
        d_ctl.put_score = 1'b1;
        d_ctl.score_sel = sel_r;
      end
    end else begin
      d_slot           = 6'(scan_slot);
      d_ctl.shift_down = 1'b1;
      d_del            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == skrt_pkg::S_DEC) begin
      stat_r <= d_stat;
      slot_r <= d_slot;
      rd_r   <= d_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      ins_r <= 1'b0;
      del_r <= 1'b0;
    end else if (state_r == skrt_pkg::S_DEC) begin
      ctl_r <= d_ctl;
      ins_r <= d_ins;
      del_r <= d_del;
    end
  end

  // Record count
  always_comb begin
    count_nxt = count_r;
    if (apply_go && ins_r) begin
      count_nxt = count_r + CW'(1);
    end else if (apply_go && del_r) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register
  skrt_pkg::status_t out_stat_r;
  logic [5:0]        out_slot_r;
  logic [6:0]        out_cnt_r;
  logic [3:0][15:0]  out_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (apply_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_stat_r <= stat_r;
      out_slot_r <= slot_r;
      out_cnt_r  <= 7'(count_nxt);
      out_rd_r   <= rd_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {3'b000, out_rd_r[3], out_rd_r[2], out_rd_r[1], out_rd_r[0],
                       out_cnt_r, out_slot_r};

  // Checks
  `CHK_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `CHK_IMPL(a_out_from_apply, clk, rst_n, $rose(out_tvalid_r), $past(state_r) == skrt_pkg::S_APPLY)
  `CHK_NEXT(a_insert_count, clk, rst_n, apply_go && ins_r, count_r == $past(count_r) + CW'(1))

endmodule

`default_nettype wire
